@@ src/ttg_pkg.sv @@
// ---------------------------------------------------------------------------
// ttg_pkg
// Shared widths, types and helpers of the triangle tangent generator.
// ---------------------------------------------------------------------------
package ttg_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int TANGENT_WIDTH = 16;

    // signed difference of two coordinates
    localparam int DIFF_W = COORD_WIDTH + 1;
    // magnitude product, kept modulo 2^64
    localparam int PROD_W = (2 * COORD_WIDTH + 1 > 64) ? 64 : 2 * COORD_WIDTH + 1;
    localparam int TERM_W = PROD_W + 1;
    localparam int TAN_W  = TERM_W + 1;
    localparam int MAG_W  = TAN_W;
    localparam int BL_W   = $clog2(MAG_W + 1);
    localparam int NORM_W = 31;
    localparam int MOP_W  = (DIFF_W > NORM_W) ? DIFF_W : NORM_W;
    localparam int SUM_W  = 64;
    localparam int ROOT_W = 32;
    localparam int QUO_W  = TANGENT_WIDTH;
    localparam int DIV_W  = ROOT_W + TANGENT_WIDTH - 1;
    localparam int CNT_W  = $clog2(ROOT_W);
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [QUO_W-1:0] MAX_POS = {1'b0, {(QUO_W-1){1'b1}}};

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]      t_diff;

    typedef struct packed {
        t_diff e1x;
        t_diff e1y;
        t_diff e1z;
        t_diff e2x;
        t_diff e2y;
        t_diff e2z;
        t_diff du1;
        t_diff dv1;
        t_diff du2;
        t_diff dv2;
    } t_job;

    typedef struct packed {
        logic can_push;
        logic can_pop;
    } t_qstat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_LOAD,
        ST_DIV
    } t_state;

    function automatic t_diff dsub(t_coord a, t_coord b);
        return t_diff'({a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b});
    endfunction

    function automatic logic [DIFF_W-1:0] dmag(t_diff a);
        return a[DIFF_W-1] ? DIFF_W'(-a) : DIFF_W'(a);
    endfunction

endpackage

@@ src/ttg_vtx_if.sv @@
// ---------------------------------------------------------------------------
// ttg_vtx_if
// Vertex channel: position and texture coordinate, valid/ready.
// ---------------------------------------------------------------------------
interface ttg_vtx_if import ttg_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord pos_x;
    t_coord pos_y;
    t_coord pos_z;
    t_coord tex_u;
    t_coord tex_v;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

@@ src/ttg_tan_if.sv @@
// ---------------------------------------------------------------------------
// ttg_tan_if
// Tangent channel: unit tangent per corner, valid/ready.
// ---------------------------------------------------------------------------
interface ttg_tan_if import ttg_pkg::*; ();
    logic                            valid;
    logic                            ready;
    logic signed [TANGENT_WIDTH-1:0] tangent_x;
    logic signed [TANGENT_WIDTH-1:0] tangent_y;
    logic signed [TANGENT_WIDTH-1:0] tangent_z;
    logic [1:0]                      corner;
    logic                            degenerate;
    logic                            last_of_triangle;

    modport source (output valid, tangent_x, tangent_y, tangent_z, corner, degenerate,
                    last_of_triangle, input ready);
    modport sink   (input valid, tangent_x, tangent_y, tangent_z, corner, degenerate,
                    last_of_triangle, output ready);
endinterface

@@ src/ttg_front.sv @@
// ---------------------------------------------------------------------------
// ttg_front
// Collects three vertices, holds the first two and queues the edge and
// uv differences of each triangle.
// ---------------------------------------------------------------------------
module ttg_front import ttg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ttg_vtx_if.sink    i_vtx,
    input  t_qstat     i_qstat,
    output logic       o_push,
    output t_job       o_job
);

    t_coord     r_hp [0:5];
    t_coord     r_ht [0:3];
    logic [1:0] r_phase;
    logic       w_acc;
    logic       w_third;

    // third vertex (or the unused phase three) needs a queue slot
    assign w_third     = r_phase[1];
    assign i_vtx.ready = !w_third || i_qstat.can_push;
    assign w_acc       = i_vtx.valid && i_vtx.ready;
    assign o_push      = w_acc && w_third;

    always_comb begin
        o_job.e1x = dsub(r_hp[3], r_hp[0]);
        o_job.e1y = dsub(r_hp[4], r_hp[1]);
        o_job.e1z = dsub(r_hp[5], r_hp[2]);
        o_job.e2x = dsub(i_vtx.pos_x, r_hp[0]);
        o_job.e2y = dsub(i_vtx.pos_y, r_hp[1]);
        o_job.e2z = dsub(i_vtx.pos_z, r_hp[2]);
        o_job.du1 = dsub(r_ht[2], r_ht[0]);
        o_job.dv1 = dsub(r_ht[3], r_ht[1]);
        o_job.du2 = dsub(i_vtx.tex_u, r_ht[0]);
        o_job.dv2 = dsub(i_vtx.tex_v, r_ht[1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
        end else if (w_acc) begin
            r_phase <= w_third ? 2'd0 : r_phase + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            unique case (r_phase)
                2'd0: begin
                    r_hp[0] <= i_vtx.pos_x;
                    r_hp[1] <= i_vtx.pos_y;
                    r_hp[2] <= i_vtx.pos_z;
                    r_ht[0] <= i_vtx.tex_u;
                    r_ht[1] <= i_vtx.tex_v;
                end
                2'd1: begin
                    r_hp[3] <= i_vtx.pos_x;
                    r_hp[4] <= i_vtx.pos_y;
                    r_hp[5] <= i_vtx.pos_z;
                    r_ht[2] <= i_vtx.tex_u;
                    r_ht[3] <= i_vtx.tex_v;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ src/ttg_queue.sv @@
// ---------------------------------------------------------------------------
// ttg_queue
// Short queue of triangle jobs between the front and the back.
// ---------------------------------------------------------------------------
module ttg_queue import ttg_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_job,
    output t_qstat o_qstat
);

    t_job              r_mem [0:QDEPTH-1];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_qstat.can_push = (r_cnt != QCNT_W'(QDEPTH));
    assign o_qstat.can_pop  = (r_cnt != '0);
    assign o_job            = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != QCNT_W'(QDEPTH)) || i_pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0)
        else $error("pop from empty queue");

endmodule

@@ src/ttg_back.sv @@
// ---------------------------------------------------------------------------
// ttg_back
// Per-triangle sequencer: shared multiplier for products and squares,
// bit-pair square root, restoring divider, then three result beats.
// ---------------------------------------------------------------------------
module ttg_back import ttg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  t_qstat     i_qstat,
    output logic       o_pop,
    ttg_tan_if.source  o_tan
);

    t_state                    r_state;
    t_state                    n_state;
    logic                      r_out;
    logic                      n_out;
    logic [CNT_W-1:0]          r_cnt;
    t_job                      r_job;
    logic [2*MOP_W-1:0]        r_prod;
    logic                      r_pneg;
    logic signed [TERM_W-1:0]  r_term [0:7];
    logic signed [TAN_W-1:0]   r_tan [0:2];
    logic                      r_det_neg;
    logic [NORM_W-1:0]         r_m [0:2];
    logic [2:0]                r_tneg;
    logic                      r_degen;
    logic [SUM_W-1:0]          r_sum;
    logic [SUM_W-1:0]          r_root;
    logic [SUM_W-1:0]          r_bit;
    logic [ROOT_W-1:0]         r_len;
    logic [1:0]                r_comp;
    logic [DIV_W-1:0]          r_rem;
    logic [DIV_W-1:0]          r_dsr;
    logic [QUO_W-1:0]          r_quo;
    logic [TANGENT_WIDTH-1:0]  r_res [0:2];
    logic [1:0]                r_corner;

    // multiplier operands
    t_diff                     w_a;
    t_diff                     w_b;
    logic [MOP_W-1:0]          w_ma;
    logic [MOP_W-1:0]          w_mb;
    logic                      w_mneg;
    // product term of the previous issue
    logic [PROD_W-1:0]         w_p;
    logic signed [TERM_W-1:0]  w_t;
    logic                      w_tneg;
    // differences
    logic signed [TAN_W-1:0]   w_det;
    logic signed [TAN_W-1:0]   w_tan [0:2];
    logic                      w_degen;
    // normalising shift
    logic [MAG_W-1:0]          w_mag [0:2];
    logic [MAG_W-1:0]          w_or;
    logic [BL_W-1:0]           w_bl;
    logic [BL_W-1:0]           w_sh;
    // square root step
    logic [SUM_W-1:0]          w_trial;
    logic                      w_sq_ge;
    logic [SUM_W-1:0]          w_nroot;
    // divider step
    logic [NORM_W-1:0]         w_msel;
    logic                      w_dge;
    logic [QUO_W-1:0]          w_nquo;
    logic [QUO_W-1:0]          w_qsat;
    logic                      w_qneg;
    logic [TANGENT_WIDTH-1:0]  w_qres;
    logic                      w_beat;

    assign w_beat = o_tan.valid && o_tan.ready;

    // ---------------- multiplier operand selection
    always_comb begin
        w_a    = '0;
        w_b    = '0;
        w_ma   = '0;
        w_mb   = '0;
        w_mneg = 1'b0;
        if (r_state == ST_MUL) begin
            unique case (r_cnt[2:0])
                3'd0: begin w_a = r_job.du1; w_b = r_job.dv2; end
                3'd1: begin w_a = r_job.du2; w_b = r_job.dv1; end
                3'd2: begin w_a = r_job.dv2; w_b = r_job.e1x; end
                3'd3: begin w_a = r_job.dv1; w_b = r_job.e2x; end
                3'd4: begin w_a = r_job.dv2; w_b = r_job.e1y; end
                3'd5: begin w_a = r_job.dv1; w_b = r_job.e2y; end
                3'd6: begin w_a = r_job.dv2; w_b = r_job.e1z; end
                default: begin w_a = r_job.dv1; w_b = r_job.e2z; end
            endcase
            w_ma   = MOP_W'(dmag(w_a));
            w_mb   = MOP_W'(dmag(w_b));
            w_mneg = w_a[DIFF_W-1] ^ w_b[DIFF_W-1];
        end else begin
            unique case (r_cnt[1:0])
                2'd0:    w_ma = MOP_W'(r_m[0]);
                2'd1:    w_ma = MOP_W'(r_m[1]);
                default: w_ma = MOP_W'(r_m[2]);
            endcase
            w_mb = w_ma;
        end
    end

    // ---------------- arithmetic of the current step
    always_comb begin
        w_p    = r_prod[PROD_W-1:0];
        w_tneg = r_pneg && (w_p != '0);
        w_t    = w_tneg ? -$signed({1'b0, w_p}) : $signed({1'b0, w_p});

        w_det    = TAN_W'(r_term[0]) - TAN_W'(r_term[1]);
        w_tan[0] = TAN_W'(r_term[2]) - TAN_W'(r_term[3]);
        w_tan[1] = TAN_W'(r_term[4]) - TAN_W'(r_term[5]);
        w_tan[2] = TAN_W'(r_term[6]) - TAN_W'(r_term[7]);
        w_degen  = (w_det == '0) ||
                   ((w_tan[0] == '0) && (w_tan[1] == '0) && (w_tan[2] == '0));

        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r_tan[i][TAN_W-1] ? MAG_W'(-r_tan[i]) : MAG_W'(r_tan[i]);
        end
        w_or = w_mag[0] | w_mag[1] | w_mag[2];
        w_bl = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (w_or[i]) begin
                w_bl = BL_W'(i + 1);
            end
        end
        w_sh = (w_bl > BL_W'(NORM_W)) ? w_bl - BL_W'(NORM_W) : '0;

        w_trial = r_root + r_bit;
        w_sq_ge = (r_sum >= w_trial);
        w_nroot = w_sq_ge ? (r_root >> 1) + r_bit : r_root >> 1;

        unique case (r_comp)
            2'd0:    w_msel = r_m[0];
            2'd1:    w_msel = r_m[1];
            default: w_msel = r_m[2];
        endcase
        w_dge  = (r_rem >= r_dsr);
        w_nquo = {r_quo[QUO_W-2:0], w_dge};
        w_qsat = (w_nquo > MAX_POS) ? MAX_POS : w_nquo;
        unique case (r_comp)
            2'd0:    w_qneg = r_tneg[0];
            2'd1:    w_qneg = r_tneg[1];
            default: w_qneg = r_tneg[2];
        endcase
        w_qres = w_qneg ? TANGENT_WIDTH'(-w_qsat) : TANGENT_WIDTH'(w_qsat);
    end

    // ---------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out   <= n_out;
        end
    end

    always_comb begin
        n_state = r_state;
        n_out   = r_out;
        o_pop   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (r_out) begin
                    if (w_beat && (r_corner == 2'd2)) begin
                        n_out = 1'b0;
                    end
                end else if (i_qstat.can_pop) begin
                    o_pop   = 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (r_cnt == CNT_W'(8)) begin
                    n_state = ST_SUB;
                end
            end
            ST_SUB: begin
                if (w_degen) begin
                    n_state = ST_IDLE;
                    n_out   = 1'b1;
                end else begin
                    n_state = ST_NORM;
                end
            end
            ST_NORM: n_state = ST_SQ;
            ST_SQ: begin
                if (r_cnt == CNT_W'(3)) begin
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == '0) begin
                    if (r_comp == 2'd2) begin
                        n_state = ST_IDLE;
                        n_out   = 1'b1;
                    end else begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- datapath
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        r_pneg <= w_mneg;
        unique case (r_state)
            ST_IDLE: begin
                r_cnt <= '0;
                if (o_pop) begin
                    r_job <= i_job;
                end
                if (w_beat) begin
                    r_corner <= r_corner + 2'd1;
                end
            end
            ST_MUL: begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt != '0) begin
                    r_term[r_cnt[2:0] - 3'd1] <= w_t;
                end
            end
            ST_SUB: begin
                r_tan[0]  <= w_tan[0];
                r_tan[1]  <= w_tan[1];
                r_tan[2]  <= w_tan[2];
                r_det_neg <= w_det[TAN_W-1];
                r_degen   <= w_degen;
                r_corner  <= 2'd0;
                if (w_degen) begin
                    r_res[0] <= '0;
                    r_res[1] <= '0;
                    r_res[2] <= '0;
                end
            end
            ST_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    r_m[i]    <= NORM_W'(w_mag[i] >> w_sh);
                    r_tneg[i] <= r_tan[i][TAN_W-1] ^ r_det_neg;
                end
                r_sum <= '0;
                r_cnt <= '0;
            end
            ST_SQ: begin
                if (r_cnt != '0) begin
                    r_sum <= r_sum + SUM_W'(r_prod);
                end
                if (r_cnt == CNT_W'(3)) begin
                    r_cnt  <= '0;
                    r_root <= '0;
                    r_bit  <= SUM_W'(1) << (SUM_W - 2);
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            ST_SQRT: begin
                if (w_sq_ge) begin
                    r_sum <= r_sum - w_trial;
                end
                r_root <= w_nroot;
                r_bit  <= r_bit >> 2;
                r_cnt  <= r_cnt + CNT_W'(1);
                r_comp <= 2'd0;
                // zero length cannot occur on a live triangle, kept as a guard
                r_len  <= (w_nroot == '0) ? ROOT_W'(1) : w_nroot[ROOT_W-1:0];
            end
            ST_LOAD: begin
                r_rem <= (DIV_W'(w_msel) << (TANGENT_WIDTH - 1)) + DIV_W'(r_len >> 1);
                r_dsr <= DIV_W'(r_len) << (TANGENT_WIDTH - 1);
                r_quo <= '0;
                r_cnt <= CNT_W'(TANGENT_WIDTH - 1);
            end
            ST_DIV: begin
                if (w_dge) begin
                    r_rem <= r_rem - r_dsr;
                end
                r_dsr <= r_dsr >> 1;
                r_quo <= w_nquo;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_res[r_comp] <= w_qres;
                    r_comp        <= r_comp + 2'd1;
                    r_corner      <= 2'd0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_tan.valid            = r_out;
    assign o_tan.tangent_x        = r_res[0];
    assign o_tan.tangent_y        = r_res[1];
    assign o_tan.tangent_z        = r_res[2];
    assign o_tan.corner           = r_corner;
    assign o_tan.degenerate       = r_degen;
    assign o_tan.last_of_triangle = (r_corner == 2'd2);

    a_corner_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tan.valid |-> r_corner != 2'd3)
        else $error("corner out of range");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_beat && o_tan.last_of_triangle) |=> !o_tan.valid)
        else $error("results continue after last corner");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tan.valid && o_tan.degenerate) |->
            (o_tan.tangent_x == '0 && o_tan.tangent_y == '0 && o_tan.tangent_z == '0))
        else $error("degenerate triangle with non-zero tangent");

endmodule

@@ src/triangle_tangent_generator_unit.sv @@
// ---------------------------------------------------------------------------
// triangle_tangent_generator_unit
// Vertex stream in, one unit tangent per corner out.
// The back works through a 32-step square root and three 16-step divisions
// per triangle; a degenerate triangle skips both and yields zero tangents.
// Throughput: one vertex a cycle into the front while the two-job queue has
// room; the back pops the next job only after the last corner has left.
// Reset: synchronous active low, clears vertex phase, queue and sequencer.
// ---------------------------------------------------------------------------
module triangle_tangent_generator_unit import ttg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ttg_vtx_if.sink    i_vtx,
    ttg_tan_if.source  o_tan
);

    t_qstat w_qstat;
    logic   w_push;
    logic   w_pop;
    t_job   w_job_in;
    t_job   w_job_out;

    ttg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (i_vtx),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_job   (w_job_in)
    );

    ttg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_qstat (w_qstat)
    );

    ttg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_job_out),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_tan   (o_tan)
    );

endmodule
